// ----- rtl/fcsi_pkg.sv -----
package fcsi_pkg;

    // CRC-32 (IEEE 802.3), reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Fixed FCS patterns for the declared modes
    localparam logic [31:0] FCS_ZERO     = 32'h0000_0000;
    localparam logic [31:0] FCS_GOOD     = 32'hC00D_C00D;
    localparam logic [31:0] FCS_BAD      = 32'hBAAD_BAAD;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_GOOD     = 2'd1,
        MODE_BAD      = 2'd2,
        MODE_COMPUTED = 2'd3
    } t_fcs_mode;

    localparam t_fcs_mode MODE_RESET = MODE_COMPUTED;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_fragment;
        logic       last_fragment;
    } t_fcs_in;

    typedef struct packed {
        logic [31:0] fcs_value;
        logic        inverted_flag;
    } t_fcs_out;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                  input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/fcsi_fcs_calc.sv -----
module fcsi_fcs_calc
    import fcsi_pkg::*;
(
    input  logic [31:0] i_crc,
    input  t_fcs_in     i_item,
    input  t_fcs_mode   i_mode,
    output logic [31:0] o_crc_next,
    output t_fcs_out    o_result
);

    logic [31:0] crc_folded;

    // Fold the byte, reload after the final byte of a fragment
    assign crc_folded = crc_fold_byte(i_crc, i_item.data_byte);
    assign o_crc_next = i_item.end_of_fragment ? CRC_INIT : crc_folded;

    // Select the FCS for the current mode
    always_comb begin
        o_result.inverted_flag = i_item.last_fragment;
        case (i_mode)
            MODE_DISABLED: o_result.fcs_value = FCS_ZERO;
            MODE_GOOD:     o_result.fcs_value = FCS_GOOD;
            MODE_BAD:      o_result.fcs_value = FCS_BAD;
            MODE_COMPUTED: o_result.fcs_value = i_item.last_fragment ? crc_folded
                                                                     : ~crc_folded;
            default:       o_result.fcs_value = FCS_ZERO;
        endcase
    end

endmodule

// ----- rtl/fragment_fcs_insertion_unit.sv -----
// Path: an item ending a fragment waits in the input register until the result
// register is free; then its FCS is registered there and shown on the output.
// Throughput: one byte per cycle unless an end-of-fragment byte waits on a full
// result register; the byte-wide CRC fold between the stages sets that figure.
// Reset: synchronous, active low; clears both stages, reloads the CRC to all
// ones and sets the mode to computed CRC.
module fragment_fcs_insertion_unit
    import fcsi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_fcs_in   i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_fcs_out  o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic        r_in_valid;
    t_fcs_in     r_in;
    logic [31:0] r_crc;
    t_fcs_mode   r_mode;
    logic        r_out_valid;
    t_fcs_out    r_out;

    logic [31:0] n_crc;
    t_fcs_out    n_out;
    logic        out_free;
    logic        stage_adv;
    logic        in_take;

    // Handshake: a byte that ends no fragment always moves on
    assign out_free  = !r_out_valid || i_out_ready;
    assign stage_adv = r_in_valid && (!r_in.end_of_fragment || out_free);
    assign in_take   = i_in_valid && o_in_ready;

    assign o_in_ready  = !r_in_valid || stage_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    fcsi_fcs_calc u_calc (
        .i_crc      (r_crc),
        .i_item     (r_in),
        .i_mode     (r_mode),
        .o_crc_next (n_crc),
        .o_result   (n_out)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
            r_mode      <= MODE_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (stage_adv) begin
                r_in_valid <= 1'b0;
            end
            if (stage_adv) begin
                r_crc <= n_crc;
            end
            if (stage_adv && r_in.end_of_fragment) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_mode <= t_fcs_mode'(i_cfg_data);
            end
        end
    end

    // Payload registers: hold input byte, capture result
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (stage_adv && r_in.end_of_fragment) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/fcsi_checker.sv -----
module fcsi_checker
    import fcsi_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input logic     i_in_ready,
    input logic     i_cfg_valid,
    input logic     i_cfg_ready,
    input t_fcs_out i_out_item
);

    // Hold a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("stalled result changed or dropped");

    // Input side never stalls when the result side can move
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with free result stage");

    // Leave reset ready for items
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> i_in_ready && !i_out_valid)
        else $error("not idle after reset");

    // Take configuration writes at once
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> i_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind fragment_fcs_insertion_unit fcsi_checker u_fcsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_in_ready  (o_in_ready),
    .i_cfg_valid (i_cfg_valid),
    .i_cfg_ready (o_cfg_ready),
    .i_out_item  (o_out_item)
);

// ----- test/tb.sv -----
module tb;
    import fcsi_pkg::*;

    localparam int SETTLE_CYCLES   = 4;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_ITEMS     = 55;

    // Track the running CRC and the FCS values still owed by the block
    class fcs_tracker;
        t_fcs_mode   mode;
        logic [31:0] crc;
        t_fcs_out    fcs_pending[$];
        int          mismatches;

        function new();
            mode       = MODE_RESET;
            crc        = CRC_INIT;
            mismatches = 0;
        endfunction

        // Shift one byte into the CRC, lowest bit first
        function logic [31:0] crc_advance(logic [31:0] c, logic [7:0] d);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ d[i];
                c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
            end
            return c;
        endfunction

        // Fold an accepted byte; at the end of a fragment queue its FCS
        function void note_byte(t_fcs_in b);
            t_fcs_out r;
            crc = crc_advance(crc, b.data_byte);
            if (b.end_of_fragment) begin
                case (mode)
                    MODE_DISABLED: r.fcs_value = FCS_ZERO;
                    MODE_GOOD:     r.fcs_value = FCS_GOOD;
                    MODE_BAD:      r.fcs_value = FCS_BAD;
                    default:       r.fcs_value = b.last_fragment ? crc : ~crc;
                endcase
                r.inverted_flag = b.last_fragment;
                fcs_pending.push_back(r);
                crc = CRC_INIT;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("tb: mismatch on %s: got %h, want %h", what, got, want);
        endtask

        // Compare an accepted result with the oldest queued FCS
        task check_fcs(t_fcs_out got);
            t_fcs_out want;
            if (fcs_pending.size() == 0) begin
                report("unexpected FCS item", got.fcs_value, 32'd0);
                return;
            end
            want = fcs_pending.pop_front();
            if (got.fcs_value !== want.fcs_value) begin
                report("fcs_value", got.fcs_value, want.fcs_value);
            end
            if (got.inverted_flag !== want.inverted_flag) begin
                report("inverted_flag", {31'd0, got.inverted_flag},
                       {31'd0, want.inverted_flag});
            end
        endtask

        function int pending();
            return fcs_pending.size();
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_fcs_in    in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_fcs_out   out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = '0;

    fcs_tracker tracker = new();
    int         idle_cycles = 0;
    int         hold_len = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;

    fragment_fcs_insertion_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Observe handshakes and run the watchdog
    always @(posedge clk) begin
        if (cfg_valid && cfg_ready) begin
            tracker.mode = t_fcs_mode'(cfg_data);
        end
        if (in_valid && in_ready) begin
            tracker.note_byte(in_item);
        end
        if (out_valid && out_ready) begin
            tracker.check_fcs(out_item);
        end
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
                || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Stall the result side on a rotating mask; hold off on request
    initial begin : receiver
        logic [7:0] stall_mask;
        int         n;
        int         cyc;
        stall_mask = 8'hFF;
        cyc        = 0;
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end else begin
                if (cyc % 64 == 0) begin
                    stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                    if (stall_mask == 8'h00) begin
                        stall_mask = 8'h01;
                    end
                end
                out_ready <= stall_mask[cyc % 8];
                cyc++;
            end
        end
    end

    // Offer one byte and hold it until accepted
    task automatic send_byte(input logic [7:0] d, input logic eof, input logic last);
        in_item  <= '{data_byte: d, end_of_fragment: eof, last_fragment: last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Send a byte inside random bursts separated by random gaps
    task automatic send_paced(input logic [7:0] d, input logic eof, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_byte(d, eof, last);
    endtask

    // Drop valid and wait until every queued FCS has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input t_fcs_mode m);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        string     check_seq;
        int        frag_left;
        t_fcs_mode phase_mode;
        logic      eof;
        check_seq = "123456789";
        frag_left = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte fragments at the byte extremes, both last flags
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        // Standard check string
        for (int i = 0; i < 9; i++) begin
            send_byte(check_seq[i], i == 8, 1'b0);
        end
        // Last flag on inner bytes is ignored; only the end byte counts
        send_byte(8'hAA, 1'b0, 1'b1);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b1);
        // Change mode while a fragment is open
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b1);
        wait_idle();
        write_mode(MODE_GOOD);
        send_byte(8'h7F, 1'b1, 1'b0);
        wait_idle();
        write_mode(MODE_DISABLED);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        wait_idle();
        write_mode(MODE_BAD);
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b1, 1'b1);

        // Random fragments, one mode per phase; fragments may span phases
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       phase_mode = MODE_DISABLED;
                1:       phase_mode = MODE_COMPUTED;
                2:       phase_mode = MODE_GOOD;
                3:       phase_mode = MODE_BAD;
                PHASE_COUNT - 1: phase_mode = MODE_COMPUTED;
                default: phase_mode = t_fcs_mode'($urandom_range(0, 3));
            endcase
            wait_idle();
            write_mode(phase_mode);
            gaps_on = (p != 3) && (p != 5);
            if (p == 5) begin
                hold_len = HOLD_OFF_CYCLES;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (frag_left == 0) begin
                    frag_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64)
                                                            : $urandom_range(1, 8);
                end
                frag_left--;
                eof = (frag_left == 0);
                send_paced(8'($urandom), eof, 1'($urandom_range(0, 1)));
            end
        end

        wait_idle();
        if (tracker.mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fcsi_pkg.sv
rtl/fcsi_fcs_calc.sv
rtl/fragment_fcs_insertion_unit.sv
rtl/fcsi_checker.sv
test/tb.sv
